// ----- rtl/rau_pkg.sv -----
// rau_pkg: shared constants, operation codes and interface types of the
// rational arithmetic unit. No dependencies.
package rau_pkg;

  localparam int DATA_WIDTH = 32;
  localparam int WIDE       = 2 * DATA_WIDTH;
  localparam int CNT_W      = $clog2(WIDE + 1);

  localparam logic [WIDE-1:0] LIM = (WIDE'(1) << (DATA_WIDTH - 1)) - WIDE'(1);

  // command codes
  localparam logic [1:0] CMD_NORM = 2'd0;
  localparam logic [1:0] CMD_ADD  = 2'd1;
  localparam logic [1:0] CMD_NEG  = 2'd2;
  localparam logic [1:0] CMD_CMP  = 2'd3;

  typedef logic [4:0] op_t;

  localparam op_t OP_NONE     = 5'd0;
  localparam op_t OP_LOAD     = 5'd1;
  localparam op_t OP_SEL_A    = 5'd2;
  localparam op_t OP_SEL_B    = 5'd3;
  localparam op_t OP_ZERO     = 5'd4;
  localparam op_t OP_GCD_INIT = 5'd5;
  localparam op_t OP_DIV_GCD  = 5'd6;
  localparam op_t OP_GCD_STEP = 5'd7;
  localparam op_t OP_DIV_NUM  = 5'd8;
  localparam op_t OP_SET_NUM  = 5'd9;
  localparam op_t OP_DIV_DEN  = 5'd10;
  localparam op_t OP_SET_DEN  = 5'd11;
  localparam op_t OP_SAVE_A   = 5'd12;
  localparam op_t OP_SAVE_B   = 5'd13;
  localparam op_t OP_MUL_P    = 5'd14;
  localparam op_t OP_MUL_Q    = 5'd15;
  localparam op_t OP_MUL_D    = 5'd16;
  localparam op_t OP_SEL_SUM  = 5'd17;
  localparam op_t OP_CMP_P    = 5'd18;
  localparam op_t OP_CMP_Q    = 5'd19;
  localparam op_t OP_CMP_RES  = 5'd20;
  localparam op_t OP_FORM     = 5'd21;

  typedef struct packed {
    op_t  op;
    logic push;
  } dp_ctrl_t;

  typedef struct packed {
    logic [1:0] cmd;
    logic       n_zero;
    logic       ga_zero;
    logic       div_busy;
  } dp_stat_t;

  typedef struct packed {
    logic                    overflow;
    logic                    undefined;
    logic                    is_equal;
    logic [DATA_WIDTH-2:0]   res_den;
    logic [DATA_WIDTH-1:0]   res_num;
  } res_t;

  function automatic logic [DATA_WIDTH-1:0] mag_of(input logic [DATA_WIDTH-1:0] x);
    return x[DATA_WIDTH-1] ? (~x + DATA_WIDTH'(1)) : x;
  endfunction

endpackage

// ----- rtl/rau_div.sv -----
// rau_div: shared restoring divider, one quotient bit per cycle.
// Depends on rau_pkg.
module rau_div (
  input  logic                    clk,
  input  logic                    rst,
  input  logic                    start,
  input  logic [rau_pkg::WIDE-1:0] dividend,
  input  logic [rau_pkg::WIDE-1:0] divisor,
  output logic [rau_pkg::WIDE-1:0] quo,
  output logic [rau_pkg::WIDE-1:0] rem,
  output logic                    busy
);
  import rau_pkg::*;

  logic [CNT_W-1:0] cnt;
  logic [WIDE-1:0]  dvs;
  logic [WIDE:0]    shifted;
  logic [WIDE:0]    diff;

  assign shifted = {rem, quo[WIDE-1]};
  assign diff    = shifted - {1'b0, dvs};
  assign busy    = cnt != '0;

  always_ff @(posedge clk) begin
    if (rst) begin
      cnt <= '0;
    end else if (start) begin
      cnt <= CNT_W'(WIDE);
    end else if (busy) begin
      cnt <= cnt - CNT_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      rem <= '0;
      quo <= dividend;
      dvs <= divisor;
    end else if (busy) begin
      if (!diff[WIDE]) begin
        rem <= diff[WIDE-1:0];
        quo <= {quo[WIDE-2:0], 1'b1};
      end else begin
        rem <= shifted[WIDE-1:0];
        quo <= {quo[WIDE-2:0], 1'b0};
      end
    end
  end

endmodule

// ----- rtl/rau_dp.sv -----
// rau_dp: operand registers, shared multiplier, gcd registers and result
// forming. Depends on rau_pkg and rau_div.
module rau_dp (
  input  logic               clk,
  input  logic               rst,
  input  rau_pkg::dp_ctrl_t  ctrl,
  input  logic [1:0]         in_cmd,
  input  logic [127:0]       in_data,
  output rau_pkg::dp_stat_t  stat,
  output rau_pkg::res_t      res
);
  import rau_pkg::*;

  logic [1:0]            cmd_r;
  logic [DATA_WIDTH-1:0] an, ad, bn, bd;
  logic                  nn, dn;
  logic [WIDE-1:0]       nm, dm, ga, gb;
  logic                  rn_neg, rundef;
  logic [WIDE-1:0]       rn, rd;
  logic                  fa_neg, fb_neg;
  logic [DATA_WIDTH-1:0] fa_num, fa_den, fb_num, fb_den;
  logic [WIDE-1:0]       p, q, dd;
  logic [DATA_WIDTH-1:0] mul_a, mul_b;
  logic [WIDE-1:0]       prod;
  logic                  div_start;
  logic [WIDE-1:0]       div_n, div_d, quo, rem;
  logic                  div_busy;
  logic                  p_ge_q;
  logic                  sign_eq;
  logic [DATA_WIDTH-1:0] num_out;

  always_comb begin
    unique case (ctrl.op)
      OP_CMP_P: begin mul_a = mag_of(an);  mul_b = mag_of(bd);  end
      OP_CMP_Q: begin mul_a = mag_of(ad);  mul_b = mag_of(bn);  end
      OP_MUL_P: begin mul_a = fa_den;      mul_b = fb_num;      end
      OP_MUL_Q: begin mul_a = fa_num;      mul_b = fb_den;      end
      default:  begin mul_a = fa_den;      mul_b = fb_den;      end
    endcase
  end
  assign prod = WIDE'(mul_a) * WIDE'(mul_b);

  always_comb begin
    div_start = 1'b1;
    unique case (ctrl.op)
      OP_DIV_GCD: begin div_n = gb; div_d = ga; end
      OP_DIV_NUM: begin div_n = nm; div_d = gb; end
      OP_DIV_DEN: begin div_n = dm; div_d = gb; end
      default: begin
        div_n     = nm;
        div_d     = gb;
        div_start = 1'b0;
      end
    endcase
  end

  rau_div u_div (
    .clk      (clk),
    .rst      (rst),
    .start    (div_start),
    .dividend (div_n),
    .divisor  (div_d),
    .quo      (quo),
    .rem      (rem),
    .busy     (div_busy)
  );

  assign p_ge_q  = p >= q;
  assign sign_eq = (an[DATA_WIDTH-1] ^ bd[DATA_WIDTH-1]) == (ad[DATA_WIDTH-1] ^ bn[DATA_WIDTH-1]);
  assign num_out = rn_neg ? (~rn[DATA_WIDTH-1:0] + DATA_WIDTH'(1)) : rn[DATA_WIDTH-1:0];

  always_ff @(posedge clk) begin
    unique case (ctrl.op)
      OP_LOAD: begin
        cmd_r <= in_cmd;
        an    <= in_data[31:0];
        ad    <= in_data[63:32];
        bn    <= in_data[95:64];
        bd    <= in_data[127:96];
      end
      OP_SEL_A: begin
        nn <= an[DATA_WIDTH-1] ^ (cmd_r == CMD_NEG);
        nm <= WIDE'(mag_of(an));
        dn <= ad[DATA_WIDTH-1];
        dm <= WIDE'(mag_of(ad));
      end
      OP_SEL_B: begin
        nn <= bn[DATA_WIDTH-1];
        nm <= WIDE'(mag_of(bn));
        dn <= bd[DATA_WIDTH-1];
        dm <= WIDE'(mag_of(bd));
      end
      OP_SEL_SUM: begin
        dn <= 1'b0;
        dm <= dd;
        if (fb_neg == fa_neg) begin
          nn <= fb_neg;
          nm <= p + q;
        end else if (p_ge_q) begin
          nn <= fb_neg;
          nm <= p - q;
        end else begin
          nn <= fa_neg;
          nm <= q - p;
        end
      end
      OP_ZERO: begin
        rn     <= '0;
        rn_neg <= 1'b0;
        rd     <= (dm == '0) ? WIDE'(0) : WIDE'(1);
        rundef <= dm == '0;
      end
      OP_GCD_INIT: begin
        ga <= nm;
        gb <= dm;
      end
      OP_GCD_STEP: begin
        gb <= ga;
        ga <= rem;
      end
      OP_SET_NUM: begin
        rn     <= quo;
        rn_neg <= nn ^ (dn && dm != '0);
        rundef <= dm == '0;
      end
      OP_SET_DEN: rd <= quo;
      OP_SAVE_A: begin
        fa_neg <= rn_neg;
        fa_num <= rn[DATA_WIDTH-1:0];
        fa_den <= rd[DATA_WIDTH-1:0];
      end
      OP_SAVE_B: begin
        fb_neg <= rn_neg;
        fb_num <= rn[DATA_WIDTH-1:0];
        fb_den <= rd[DATA_WIDTH-1:0];
      end
      OP_MUL_P, OP_CMP_P: p  <= prod;
      OP_MUL_Q, OP_CMP_Q: q  <= prod;
      OP_MUL_D:           dd <= prod;
      OP_CMP_RES: begin
        res.res_num   <= '0;
        res.res_den   <= '0;
        res.is_equal  <= (p == q) && (p == '0 || sign_eq);
        res.undefined <= 1'b0;
        res.overflow  <= 1'b0;
      end
      OP_FORM: begin
        res.res_num   <= num_out;
        res.res_den   <= rd[DATA_WIDTH-2:0];
        res.is_equal  <= 1'b0;
        res.undefined <= rundef;
        res.overflow  <= (rd > LIM) || (rn > LIM + WIDE'(rn_neg));
      end
      default: begin
      end
    endcase
  end

  assign stat.cmd      = cmd_r;
  assign stat.n_zero   = nm == '0;
  assign stat.ga_zero  = ga == '0;
  assign stat.div_busy = div_busy;

endmodule

// ----- rtl/rau_ctrl.sv -----
// rau_ctrl: sequencer for normalise, add, negate and compare.
// Depends on rau_pkg; drives rau_dp through dp_ctrl_t.
module rau_ctrl (
  input  logic               clk,
  input  logic               rst,
  input  logic               in_valid,
  input  logic               out_free,
  input  rau_pkg::dp_stat_t  stat,
  output logic               in_ready,
  output rau_pkg::dp_ctrl_t  ctrl
);
  import rau_pkg::*;

  localparam logic [3:0] S_IDLE = 4'd0;
  localparam logic [3:0] S_DISP = 4'd1;
  localparam logic [3:0] S_NORM = 4'd2;
  localparam logic [3:0] S_GCD  = 4'd3;
  localparam logic [3:0] S_WGCD = 4'd4;
  localparam logic [3:0] S_WNUM = 4'd5;
  localparam logic [3:0] S_SDEN = 4'd6;
  localparam logic [3:0] S_WDEN = 4'd7;
  localparam logic [3:0] S_RET  = 4'd8;
  localparam logic [3:0] S_SELB = 4'd9;
  localparam logic [3:0] S_MP   = 4'd10;
  localparam logic [3:0] S_MQ   = 4'd11;
  localparam logic [3:0] S_MD   = 4'd12;
  localparam logic [3:0] S_SUM  = 4'd13;
  localparam logic [3:0] S_CMPQ = 4'd14;
  localparam logic [3:0] S_OUT  = 4'd15;

  localparam logic [1:0] PH_A     = 2'd0;
  localparam logic [1:0] PH_B     = 2'd1;
  localparam logic [1:0] PH_FINAL = 2'd2;

  logic [3:0] state, state_next;
  logic [1:0] phase, phase_next;

  assign in_ready = state == S_IDLE;

  always_comb begin
    state_next = state;
    phase_next = phase;
    ctrl.op    = OP_NONE;
    ctrl.push  = 1'b0;
    unique case (state)
      S_IDLE: begin
        if (in_valid) begin
          ctrl.op    = OP_LOAD;
          state_next = S_DISP;
        end
      end
      S_DISP: begin
        if (stat.cmd == CMD_CMP) begin
          ctrl.op    = OP_CMP_P;
          state_next = S_CMPQ;
        end else begin
          ctrl.op    = OP_SEL_A;
          phase_next = (stat.cmd == CMD_ADD) ? PH_A : PH_FINAL;
          state_next = S_NORM;
        end
      end
      S_NORM: begin
        if (stat.n_zero) begin
          ctrl.op    = OP_ZERO;
          state_next = S_RET;
        end else begin
          ctrl.op    = OP_GCD_INIT;
          state_next = S_GCD;
        end
      end
      S_GCD: begin
        if (stat.ga_zero) begin
          ctrl.op    = OP_DIV_NUM;
          state_next = S_WNUM;
        end else begin
          ctrl.op    = OP_DIV_GCD;
          state_next = S_WGCD;
        end
      end
      S_WGCD: begin
        if (!stat.div_busy) begin
          ctrl.op    = OP_GCD_STEP;
          state_next = S_GCD;
        end
      end
      S_WNUM: begin
        if (!stat.div_busy) begin
          ctrl.op    = OP_SET_NUM;
          state_next = S_SDEN;
        end
      end
      S_SDEN: begin
        ctrl.op    = OP_DIV_DEN;
        state_next = S_WDEN;
      end
      S_WDEN: begin
        if (!stat.div_busy) begin
          ctrl.op    = OP_SET_DEN;
          state_next = S_RET;
        end
      end
      S_RET: begin
        priority case (phase)
          PH_A: begin
            ctrl.op    = OP_SAVE_A;
            state_next = S_SELB;
          end
          PH_B: begin
            ctrl.op    = OP_SAVE_B;
            state_next = S_MP;
          end
          default: begin
            ctrl.op    = OP_FORM;
            state_next = S_OUT;
          end
        endcase
      end
      S_SELB: begin
        ctrl.op    = OP_SEL_B;
        phase_next = PH_B;
        state_next = S_NORM;
      end
      S_MP: begin
        ctrl.op    = OP_MUL_P;
        state_next = S_MQ;
      end
      S_MQ: begin
        ctrl.op    = OP_MUL_Q;
        state_next = S_MD;
      end
      S_MD: begin
        ctrl.op    = OP_MUL_D;
        state_next = S_SUM;
      end
      S_SUM: begin
        ctrl.op    = OP_SEL_SUM;
        phase_next = PH_FINAL;
        state_next = S_NORM;
      end
      S_CMPQ: begin
        ctrl.op    = OP_CMP_Q;
        state_next = S_RET;
        phase_next = PH_FINAL;
      end
      S_OUT: begin
        if (out_free) begin
          ctrl.push  = 1'b1;
          state_next = S_IDLE;
        end
      end
      default: state_next = S_IDLE;
    endcase
    if (state == S_RET && phase == PH_FINAL && stat.cmd == CMD_CMP) begin
      ctrl.op = OP_CMP_RES;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      phase <= PH_FINAL;
    end else begin
      state <= state_next;
      phase <= phase_next;
    end
  end

  a_div_idle: assert property (@(posedge clk) disable iff (rst)
    (ctrl.op == OP_DIV_GCD || ctrl.op == OP_DIV_NUM || ctrl.op == OP_DIV_DEN)
      |-> !stat.div_busy)
    else $error("divider started while busy");

  a_push_free: assert property (@(posedge clk) disable iff (rst)
    ctrl.push |-> (out_free && state == S_OUT))
    else $error("result pushed into a full output stage");

  a_load_disp: assert property (@(posedge clk) disable iff (rst)
    (in_ready && in_valid) |=> state == S_DISP)
    else $error("accepted beat not dispatched");

endmodule

// ----- rtl/rational_arith_unit.sv -----
// Rational arithmetic unit: takes a command and two signed fractions per beat
// and returns one reduced fraction with flags. Depends on rau_pkg, rau_ctrl
// and rau_dp.
//
// One item is in work at a time; a finished result waits in the output
// register while the next beat is taken. Compare forms its two cross
// products in turn and needs no division. Normalise and negate reduce the
// fraction by Euclid remainder steps (at most about 47 for 32-bit operands)
// and then divide numerator and denominator by the gcd; a zero numerator
// skips the reduction. Add runs three such reductions, the last on values up
// to 63 bits (at most about 92 steps); its three products are each formed in
// one state by the shared multiplier. Every remainder step and both final
// divisions go through one shared restoring divider at one quotient bit per
// cycle, which sets the latency.
module rational_arith_unit (
  input  logic         clk,
  input  logic         rst,
  input  logic         s_tvalid,
  output logic         s_tready,
  input  logic [127:0] s_tdata,   // a_num, a_den, b_num, b_den
  input  logic [1:0]   s_tuser,   // command
  output logic         m_tvalid,
  input  logic         m_tready,
  output logic [71:0]  m_tdata    // res_num, res_den, is_equal, undefined, overflow, zero pad
);
  import rau_pkg::*;

  dp_ctrl_t ctrl;
  dp_stat_t stat;
  res_t     res;
  logic     out_free;

  assign out_free = !m_tvalid || m_tready;

  rau_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (s_tvalid),
    .out_free (out_free),
    .stat     (stat),
    .in_ready (s_tready),
    .ctrl     (ctrl)
  );

  rau_dp u_dp (
    .clk     (clk),
    .rst     (rst),
    .ctrl    (ctrl),
    .in_cmd  (s_tuser),
    .in_data (s_tdata),
    .stat    (stat),
    .res     (res)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (ctrl.push) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (ctrl.push) begin
      m_tdata <= {6'd0, res};
    end
  end

endmodule

// ----- tb/sv/rational_arith_unit_tb.sv -----
`timescale 1ns / 1ps
// rational_arith_unit_tb: self-checking testbench for the rational arithmetic unit.
// Holds its own fraction predictor; drives beats from a queue and checks every result.
// Depends on rau_pkg and rational_arith_unit.
module rational_arith_unit_tb;
  import rau_pkg::*;

  typedef struct {
    logic [1:0]  cmd;
    logic [31:0] an, ad, bn, bd;
  } frac_op_t;

  typedef struct packed {
    logic [31:0] num;
    logic [30:0] den;
    logic        eq, undef, ovf;
  } frac_res_t;

  typedef struct {
    logic        neg;
    logic [63:0] mag;
  } sm_t;

  logic         clk = 0;
  logic         rst = 1;
  logic         s_tvalid = 0;
  logic         s_tready;
  logic [127:0] s_tdata = '0;
  logic [1:0]   s_tuser = '0;
  logic         m_tvalid;
  logic         m_tready = 0;
  logic [71:0]  m_tdata;

  frac_op_t  pending_ops[$];
  frac_res_t expected_results[$];
  int        send_idle_pct = 0;
  int        recv_stall_pct = 0;
  int        hold_off = 0;
  bit        hold_req = 0;
  bit        hold_seen = 0;
  int        errors = 0;
  int        cycle_count = 0;

  rational_arith_unit dut (.*);

  always begin
    #1 clk = 1;
    #1 clk = 0;
  end

  function automatic sm_t to_sm(logic [31:0] v);
    sm_t r;
    r.neg = v[31];
    r.mag = v[31] ? (64'd0 - {32'hffff_ffff, v}) : {32'd0, v};
    return r;
  endfunction

  function automatic logic [63:0] euclid_gcd(logic [63:0] a, logic [63:0] b);
    logic [63:0] c;
    while (a != 0) begin
      c = a;
      a = b % a;
      b = c;
    end
    return b;
  endfunction

  // reduced fraction: num sign/mag, den mag, undef
  function automatic void reduce(sm_t n, sm_t d, output sm_t rn, output logic [63:0] rd,
                                 output logic und);
    logic [63:0] g;
    if (n.mag == 0) n.neg = 0;
    if (d.mag == 0) d.neg = 0;
    und = (d.mag == 0);
    if (n.mag == 0) begin
      rn.neg = 0;
      rn.mag = 0;
      rd = und ? 64'd0 : 64'd1;
      return;
    end
    g = euclid_gcd(n.mag, d.mag);
    rn.neg = n.neg != d.neg;
    rn.mag = n.mag / g;
    rd = d.mag / g;
  endfunction

  function automatic frac_res_t predict_fraction(frac_op_t op);
    frac_res_t r;
    sm_t rn, na, nb, p, q, s, d;
    logic [63:0] rd, da, db, lim;
    logic und, ua, ub;
    lim = 64'h7fff_ffff;
    r = '{default: 0};
    if (op.cmd == CMD_CMP) begin
      r.eq = ($signed(64'($signed(op.an))) * $signed(64'($signed(op.bd)))) ==
             ($signed(64'($signed(op.ad))) * $signed(64'($signed(op.bn))));
      return r;
    end
    if (op.cmd == CMD_NORM) reduce(to_sm(op.an), to_sm(op.ad), rn, rd, und);
    else if (op.cmd == CMD_NEG) begin
      na = to_sm(op.an);
      na.neg = !na.neg;
      reduce(na, to_sm(op.ad), rn, rd, und);
    end else begin
      reduce(to_sm(op.an), to_sm(op.ad), na, da, ua);
      reduce(to_sm(op.bn), to_sm(op.bd), nb, db, ub);
      p.neg = nb.neg; p.mag = da * nb.mag;
      q.neg = na.neg; q.mag = na.mag * db;
      d.neg = 0;      d.mag = da * db;
      if (p.neg == q.neg) begin
        s.neg = p.neg; s.mag = p.mag + q.mag;
      end else if (p.mag >= q.mag) begin
        s.neg = p.neg; s.mag = p.mag - q.mag;
      end else begin
        s.neg = q.neg; s.mag = q.mag - p.mag;
      end
      if (s.mag == 0) s.neg = 0;
      reduce(s, d, rn, rd, und);
    end
    r.ovf = rd > lim || rn.mag > lim + (rn.neg ? 1 : 0);
    r.num = rn.neg ? 32'(-rn.mag) : rn.mag[31:0];
    r.den = rd[30:0];
    r.undef = und;
    return r;
  endfunction

  // driver
  always @(posedge clk) begin
    if (rst) s_tvalid <= 0;
    else if (!s_tvalid || s_tready) begin
      if (s_tvalid && s_tready) void'(pending_ops.pop_front());
      if (pending_ops.size() > 0 && $urandom_range(99) >= send_idle_pct) begin
        frac_op_t op;
        op = pending_ops[0];
        s_tvalid <= 1;
        s_tdata <= {op.bd, op.bn, op.ad, op.an};
        s_tuser <= op.cmd;
        expected_results.push_back(predict_fraction(op));
      end else s_tvalid <= 0;
    end
  end

  // receiver readiness
  always @(posedge clk) begin
    if (hold_req && !hold_seen) begin
      hold_seen <= 1;
      hold_off <= 20000;
      m_tready <= 0;
    end else if (hold_off > 0) begin
      hold_off <= hold_off - 1;
      m_tready <= 0;
    end else m_tready <= !rst && $urandom_range(99) >= recv_stall_pct;
  end

  // monitor
  always @(posedge clk) begin
    if (!rst && m_tvalid && m_tready) begin
      frac_res_t e, a;
      a.num = m_tdata[31:0];
      a.den = m_tdata[62:32];
      a.eq = m_tdata[63];
      a.undef = m_tdata[64];
      a.ovf = m_tdata[65];
      if (expected_results.size() == 0) begin
        $display("%0t unexpected beat %h", $time, m_tdata);
        errors++;
      end else begin
        e = expected_results.pop_front();
        if (a !== e) begin
          $display("%0t mismatch: expected num %h den %h eq %b undef %b ovf %b", $time,
                   e.num, e.den, e.eq, e.undef, e.ovf);
          $display("%0t           actual num %h den %h eq %b undef %b ovf %b", $time,
                   a.num, a.den, a.eq, a.undef, a.ovf);
          errors++;
        end
      end
    end
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > 50000000) begin
      $display("rational_arith_unit_tb: errors");
      $finish;
    end
  end

  function automatic logic [31:0] rand_val();
    case ($urandom_range(7))
      0: return 32'($urandom_range(6)) - 32'd3;
      1: return 32'($urandom_range(1000)) - 32'd500;
      2: return $urandom_range(1) ? 32'h7fff_ffff : 32'h8000_0001;
      3: return $urandom_range(1) ? 32'h8000_0000 : 32'h0;
      4: return 32'($urandom_range(64)) * 32'($urandom_range(64)) * 32'd6;
      default: return $urandom;
    endcase
  endfunction

  task automatic push_op(logic [1:0] c, logic [31:0] an, ad, bn, bd);
    frac_op_t op;
    op = '{c, an, ad, bn, bd};
    pending_ops.push_back(op);
  endtask

  task automatic drain();
    while (pending_ops.size() != 0 || expected_results.size() != 0) @(posedge clk);
  endtask

  initial begin
    logic [31:0] k;
    repeat (9) @(posedge clk);
    rst <= 0;
    // directed
    push_op(CMD_NORM, 6, -4, 0, 1);
    push_op(CMD_NORM, 0, -5, 0, 1);
    push_op(CMD_NORM, 7, 0, 0, 1);
    push_op(CMD_NORM, -7, 0, 0, 1);
    push_op(CMD_NORM, 0, 0, 0, 0);
    push_op(CMD_NORM, 32'h8000_0000, 32'hffff_ffff, 0, 1);
    push_op(CMD_NORM, 32'h7fff_ffff, 32'h8000_0000, 0, 1);
    push_op(CMD_NEG, 32'h8000_0000, 1, 0, 1);
    push_op(CMD_NEG, 3, -9, 0, 1);
    push_op(CMD_NEG, 0, 0, 0, 0);
    push_op(CMD_ADD, 1, 2, 1, 3);
    push_op(CMD_ADD, 1, 2, -1, 2);
    push_op(CMD_ADD, 1, 0, 1, 2);
    push_op(CMD_ADD, 32'h7fff_ffff, 1, 32'h7fff_ffff, 1);
    push_op(CMD_ADD, 1, 32'h7fff_ffff, 1, 32'h7fff_fffe);
    push_op(CMD_ADD, 32'h8000_0000, 32'h7fff_ffff, 32'h8000_0000, 32'h7fff_fffd);
    push_op(CMD_CMP, 1, 2, 2, 4);
    push_op(CMD_CMP, 1, 2, 1, 3);
    push_op(CMD_CMP, 0, 0, 5, 7);
    push_op(CMD_CMP, 32'hffff_ffff, 32'hffff_ffff, 32'h8000_0000, 32'h8000_0000);
    drain();
    for (int ph = 0; ph < 4; ph++) begin
      send_idle_pct = (ph == 1 || ph == 3) ? (ph == 3 ? 20 : 49) : 0;
      recv_stall_pct = (ph == 2 || ph == 3) ? (ph == 3 ? 20 : 49) : 0;
      for (int i = 0; i < 190; i++) begin
        k = rand_val();
        push_op(2'($urandom_range(3)), rand_val(), rand_val(), rand_val(), rand_val());
        // matching pair for compare now and then
        if ($urandom_range(9) == 0) push_op(CMD_CMP, k, 3, k * 2, 6);
        if (ph == 0 && i == 100) begin
          hold_req = 1;
        end
      end
      drain();
    end
    repeat (3000) @(posedge clk);
    if (errors == 0 && expected_results.size() == 0)
      $display("rational_arith_unit_tb: clean");
    else
      $display("rational_arith_unit_tb: errors");
    $finish;
  end
endmodule
